// ===== design/mdio_clause22_master_core_defines.svh =====
// assertion macros used by the mdio frame sequencer
`ifndef MDIO_CLAUSE22_MASTER_CORE_DEFINES_SVH
`define MDIO_CLAUSE22_MASTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MDIO_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mdio master check failed");

// next-cycle implication, disabled while reset is low
`define MDIO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mdio master check failed");

`endif

// ===== design/mdio_c22_pkg.sv =====
// ----------------------------------------------------------------------------
// mdio_c22_pkg
// Shared types and constants of the clause-22 mdio management master.
// ----------------------------------------------------------------------------
package mdio_c22_pkg;

  localparam int unsigned PreambleBitsDef = 32;
  localparam int unsigned FrameBits       = 32;
  localparam int unsigned DrivenReadBits  = 14;
  localparam int unsigned AddrW           = 5;
  localparam int unsigned DataW           = 16;
  localparam int unsigned InDataW         = 24;
  localparam int unsigned OutDataW        = 24;
  localparam int unsigned StatusW         = 3;

  typedef enum logic [StatusW-1:0] {
    StIdle     = 3'd0,
    StBusy     = 3'd1,
    StDone     = 3'd2,
    StTaError  = 3'd3,
    StRejected = 3'd4
  } status_e;

  typedef struct packed {
    logic             mdio_out;
    logic             mdio_drive;
    status_e          status;
    logic [DataW-1:0] read_data;
  } result_t;

endpackage

// ===== design/mdio_c22_frame.sv =====
// ----------------------------------------------------------------------------
// mdio_c22_frame
// Frame sequencer: holds the transaction state and works out one result
// per accepted item.
// ----------------------------------------------------------------------------
`include "mdio_clause22_master_core_defines.svh"

module mdio_c22_frame #(
  parameter int unsigned PreambleBits = mdio_c22_pkg::PreambleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mdio_c22_pkg::AddrW-1:0]    cfg_phy_i,
  input  logic                              step_i,
  input  logic                              func_i,
  input  logic                              is_read_i,
  input  logic [mdio_c22_pkg::AddrW-1:0]    reg_address_i,
  input  logic [mdio_c22_pkg::DataW-1:0]    write_data_i,
  input  logic                              mdio_in_i,
  output mdio_c22_pkg::result_t             result_o
);

  localparam int unsigned IdxW = $clog2(PreambleBits + mdio_c22_pkg::FrameBits);
  localparam int unsigned QW   = $clog2(mdio_c22_pkg::FrameBits);
  localparam logic [IdxW-1:0] PreIdx  = IdxW'(PreambleBits);
  localparam logic [QW-1:0]   QLast   = QW'(mdio_c22_pkg::FrameBits - 1);
  localparam logic [QW-1:0]   QTa1    = QW'(mdio_c22_pkg::DrivenReadBits);
  localparam logic [QW-1:0]   QTa2    = QW'(mdio_c22_pkg::DrivenReadBits + 1);

  logic [mdio_c22_pkg::AddrW-1:0]           phy_q;
  logic                                     busy_q, busy_d;
  logic                                     read_q, read_d;
  logic [IdxW-1:0]                          idx_q, idx_d;
  logic [mdio_c22_pkg::FrameBits-1:0]       shift_q, shift_d;
  logic [mdio_c22_pkg::DataW-1:0]           in_q, in_d;
  logic [IdxW-1:0]                          q_full;
  logic [QW-1:0]                            q;
  logic [mdio_c22_pkg::DataW-1:0]           in_next;
  logic                                     level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phy_q   <= '0;
      busy_q  <= 1'b0;
      read_q  <= 1'b0;
      idx_q   <= '0;
      shift_q <= '0;
      in_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        phy_q <= cfg_phy_i;
      end
      busy_q  <= busy_d;
      read_q  <= read_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      in_q    <= in_d;
    end
  end

  assign q_full  = idx_q - PreIdx;
  assign q       = q_full[QW-1:0];
  assign in_next = {in_q[mdio_c22_pkg::DataW-2:0], mdio_in_i};
  assign level   = shift_q[QLast - q];

  always_comb begin
    busy_d   = busy_q;
    read_d   = read_q;
    idx_d    = idx_q;
    shift_d  = shift_q;
    in_d     = in_q;
    result_o = '{mdio_out: 1'b0, mdio_drive: 1'b0,
                 status: mdio_c22_pkg::StIdle, read_data: '0};
    if (step_i) begin
      if (func_i) begin
        if (busy_q) begin
          result_o.status = mdio_c22_pkg::StRejected;
        end else begin
          // ST 01, OP, phy, reg, then TA 10 and data for a write
          read_d  = is_read_i;
          shift_d = {2'b01, is_read_i, ~is_read_i, phy_q, reg_address_i,
                     ~is_read_i, 1'b0,
                     is_read_i ? {mdio_c22_pkg::DataW{1'b0}} : write_data_i};
          idx_d   = '0;
          in_d    = '0;
          busy_d  = 1'b1;
          result_o.status = mdio_c22_pkg::StBusy;
        end
      end else if (busy_q) begin
        idx_d = idx_q + 1'b1;
        result_o.status = mdio_c22_pkg::StBusy;
        if (idx_q < PreIdx) begin
          result_o.mdio_out   = 1'b1;
          result_o.mdio_drive = 1'b1;
        end else if (!read_q || q < QTa1) begin
          result_o.mdio_out   = level;
          result_o.mdio_drive = 1'b1;
          if (q == QLast) begin
            busy_d = 1'b0;
            result_o.status = mdio_c22_pkg::StDone;
          end
        end else if (q == QTa1) begin
          // first turnaround bit: released, sample ignored
          result_o.status = mdio_c22_pkg::StBusy;
        end else if (q == QTa2) begin
          if (mdio_in_i) begin
            busy_d = 1'b0;
            result_o.status = mdio_c22_pkg::StTaError;
          end
        end else begin
          in_d = in_next;
          if (q == QLast) begin
            busy_d = 1'b0;
            result_o.status    = mdio_c22_pkg::StDone;
            result_o.read_data = in_next;
          end
        end
      end
    end
  end

  `MDIO_ASSERT_NEXT(a_done_goes_idle, clk_i, rst_ni,
    step_i && (result_o.status == mdio_c22_pkg::StDone), !busy_q)
  `MDIO_ASSERT_NOW(a_drive_only_busy_tick, clk_i, rst_ni,
    result_o.mdio_drive, step_i && !func_i && busy_q)
  `MDIO_ASSERT_NEXT(a_start_loads, clk_i, rst_ni,
    step_i && func_i && !busy_q, busy_q && (idx_q == '0) && (in_q == '0))
  `MDIO_ASSERT_NOW(a_data_only_on_done, clk_i, rst_ni,
    result_o.read_data != '0, result_o.status == mdio_c22_pkg::StDone)

endmodule

// ===== design/mdio_c22_outreg.sv =====
// ----------------------------------------------------------------------------
// mdio_c22_outreg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module mdio_c22_outreg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  mdio_c22_pkg::result_t result_i,
  output logic                  free_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output mdio_c22_pkg::result_t result_o
);

  logic                  valid_q;
  mdio_c22_pkg::result_t data_q;

  // free when empty or the held result leaves this cycle
  assign free_o          = !valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = valid_q;
  assign result_o        = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

// ===== design/mdio_clause22_master_core.sv =====
// a result is registered and offered in the cycle after its item is accepted
// throughput: one item per cycle; the single result register sets the pace,
//   and input stalls only while that register holds an untaken result
// reset: rst_ni low clears the phy address to 0, the master to idle and the
//   result register to empty
// ----------------------------------------------------------------------------
// mdio_clause22_master_core
// Clause-22 mdio management master, one mdc bit period per tick transfer.
// ----------------------------------------------------------------------------
module mdio_clause22_master_core #(
  parameter int unsigned PreambleBits = mdio_c22_pkg::PreambleBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mdio_c22_pkg::AddrW-1:0]        cfg_data_i,      // phy_address
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // is_read[0], reg_address[5:1], write_data[21:6], mdio_in[22], zero [23]
  input  logic [mdio_c22_pkg::InDataW-1:0]      s_axis_tdata_i,
  input  logic                                  s_axis_tuser_i,  // func
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // mdio_out[0], mdio_drive[1], read_data[17:2], zero [23:18]
  output logic [mdio_c22_pkg::OutDataW-1:0]     m_axis_tdata_o,
  output logic [mdio_c22_pkg::StatusW-1:0]      m_axis_tuser_o   // status
);

  logic                  accept;
  logic                  free;
  mdio_c22_pkg::result_t step_res;
  mdio_c22_pkg::result_t out_res;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = free;
  assign accept          = s_axis_tvalid_i && free;

  mdio_c22_frame #(
    .PreambleBits (PreambleBits)
  ) u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_phy_i     (cfg_data_i),
    .step_i        (accept),
    .func_i        (s_axis_tuser_i),
    .is_read_i     (s_axis_tdata_i[0]),
    .reg_address_i (s_axis_tdata_i[5:1]),
    .write_data_i  (s_axis_tdata_i[21:6]),
    .mdio_in_i     (s_axis_tdata_i[22]),
    .result_o      (step_res)
  );

  mdio_c22_outreg u_outreg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept),
    .result_i        (step_res),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .result_o        (out_res)
  );

  assign m_axis_tdata_o = {6'b0, out_res.read_data, out_res.mdio_drive, out_res.mdio_out};
  assign m_axis_tuser_o = out_res.status;

endmodule
